/* rtl/rfa_pkg.sv */
// ============================================================================
// Reference-counted frame allocator package
// Shared item types, operation codes, status codes, configuration register indexes
// and controller states.
package rfa_pkg;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_ADD_REF = 2'd2,
        FN_INIT    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_FREE     = 3'd1,
        ST_DOUBLE_FREE = 3'd2,
        ST_PROTECTED   = 3'd3,
        ST_STILL_REF   = 3'd4,
        ST_OUT_OF_RANGE = 3'd5,
        ST_REF_SAT     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_TOTAL_FRAMES  = 2'd0,
        CFG_FREE_START    = 2'd1,
        CFG_FREE_END      = 2'd2,
        CFG_PROTECT_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC_UPD,
        S_LOOKUP,
        S_INIT_REF,
        S_INIT_BMRD,
        S_INIT_BMWR,
        S_DONE
    } rfa_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] phys_addr;
    } rfa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_addr;
        logic [15:0] old_refs;
        logic [15:0] used_frames;
        logic [15:0] free_frames;
    } rfa_out_t;

endpackage

/* rtl/rfa_first_zero.sv */
// ============================================================================
// First zero finder
// Returns the position of the lowest clear bit of a 32-bit bitmap word.
// ============================================================================
module rfa_first_zero
    import rfa_pkg::*;
(
    input  logic [31:0] word,
    output logic        found,
    output logic [4:0]  idx
);

    logic [31:0] zeros;
    logic [31:0] lowest;

    always_comb
    begin
        zeros  = ~word;
        // Isolate the lowest set bit of the inverted word.
        lowest = zeros & (~zeros + 32'd1);
        found  = |zeros;
        idx    = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | 5'(i);
            end
        end
    end

endmodule

/* rtl/refcounted_frame_allocator.sv */
// ============================================================================
// Reference-counted page-frame allocator
// Used bitmap and per-frame reference counts kept in two synchronous memories.
// ============================================================================
// Free and add reference read the count and bitmap word, then update them as
// needed; protected or out-of-range frees skip the lookup; alloc scans bitmap
// words for a clear bit; init zeroes each count in the range, then reads and rewrites each bitmap word it touches.
// One item is in work at a time; the bitmap read port sets the scan rate.
// After reset a clearing pass fills the memories (counts 1, bitmap all ones)
// while the input is stalled; configuration is always taken.
module refcounted_frame_allocator
    import rfa_pkg::*;
#(
    parameter int FRAMES     = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int REF_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rfa_in_t     in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output rfa_out_t    out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NWORDS = (FRAMES + 31) / 32;
    localparam int FIW    = $clog2(FRAMES);
    localparam int FCW    = $clog2(FRAMES + 1);
    localparam int XW     = (FCW > 16) ? FCW : 16;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WCW    = $clog2(NWORDS + 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    // Configuration registers.
    logic [15:0] total_reg, fstart_reg, fend_reg, protect_reg;

    // The two state memories, each with one write and one registered read port.
    logic [31:0]         bm_mem [NWORDS];
    logic [REF_BITS-1:0] ref_mem [FRAMES];
    logic                bm_we, bm_re, ref_we, ref_re;
    logic [WIW-1:0]      bm_waddr, bm_raddr;
    logic [31:0]         bm_wdata, bm_rdata;
    logic [FIW-1:0]      ref_waddr, ref_raddr;
    logic [REF_BITS-1:0] ref_wdata, ref_rdata;

    // Control and result registers.
    rfa_state_t     state_reg, state_next;
    logic [FIW-1:0] fcnt_reg, fcnt_next;
    logic [WIW-1:0] wcnt_reg, wcnt_next;
    logic [WCW-1:0] issue_reg, issue_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [WCW-1:0] chk_word_reg, chk_word_next;
    logic           is_free_reg, is_free_next;
    logic [15:0]    used_reg, used_next;
    status_t        res_status_reg, res_status_next;
    logic [31:0]    res_addr_reg, res_addr_next;
    logic [15:0]    res_old_reg, res_old_next;
    logic           out_valid_reg, out_valid_next;
    rfa_out_t       out_item_reg, out_item_next;

    // Derived bounds.
    logic [XW:0]    limit_x, lim_words, base_x, rem_x;
    logic [XW:0]    start_x, end_x, last_x;
    logic [31:0]    frame32, vmask, init_mask;
    logic [31:0]    scan_word;
    logic           zf_found;
    logic [4:0]     zf_idx, mlo, mhi;
    logic [63:0]    addr_wide;
    logic [FIW-1:0] found_frame;

    rfa_first_zero u_first_zero
    (
        .word  (scan_word),
        .found (zf_found),
        .idx   (zf_idx)
    );

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata <= bm_mem[bm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (ref_re)
        begin
            ref_rdata <= ref_mem[ref_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Configuration port. It is always ready; unknown indexes cannot occur
    // with a two-bit index.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= 16'd32768;
            fstart_reg  <= 16'd4096;
            fend_reg    <= 16'd32768;
            protect_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TOTAL_FRAMES:  total_reg   <= cfg_data;
                CFG_FREE_START:    fstart_reg  <= cfg_data;
                CFG_FREE_END:      fend_reg    <= cfg_data;
                CFG_PROTECT_LIMIT: protect_reg <= cfg_data;
                default:           total_reg   <= total_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bounds used by the scan and init sequences, and frame and address conversions.
    // ------------------------------------------------------------------
    always_comb
    begin
        limit_x   = ((XW+1)'(total_reg) < (XW+1)'(FRAMES)) ? (XW+1)'(total_reg)
                                                          : (XW+1)'(FRAMES);
        lim_words = (limit_x + (XW+1)'(31)) >> 5;
        base_x    = (XW+1)'(chk_word_reg) << 5;
        rem_x     = limit_x - base_x;
        // Bits of the checked word at or past the limit count as used.
        if (rem_x >= (XW+1)'(32))
        begin
            vmask = '1;
        end
        else
        begin
            vmask = ~(32'hFFFF_FFFF << rem_x[4:0]);
        end
        scan_word   = bm_rdata | ~vmask;
        found_frame = FIW'(base_x + (XW+1)'(zf_idx));

        start_x = (XW+1)'(fstart_reg);
        end_x   = ((XW+1)'(fend_reg) < (XW+1)'(FRAMES)) ? (XW+1)'(fend_reg)
                                                       : (XW+1)'(FRAMES);
        last_x  = end_x - (XW+1)'(1);
        mlo     = ((XW+1)'(wcnt_reg) == (start_x >> 5)) ? start_x[4:0] : 5'd0;
        mhi     = ((XW+1)'(wcnt_reg) == (last_x >> 5)) ? last_x[4:0] : 5'd31;
        init_mask = (32'hFFFF_FFFF << mlo) & (32'hFFFF_FFFF >> (5'd31 - mhi));

        frame32   = in_item.phys_addr >> PAGE_SHIFT;
        addr_wide = 64'(fcnt_reg) << PAGE_SHIFT;
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            fcnt_reg      <= '0;
            wcnt_reg      <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            chk_word_reg  <= '0;
            is_free_reg   <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            wcnt_reg      <= wcnt_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            chk_word_reg  <= chk_word_next;
            is_free_reg   <= is_free_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_old_reg    <= res_old_next;
        out_item_reg   <= out_item_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fcnt_next       = fcnt_reg;
        wcnt_next       = wcnt_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_word_next   = chk_word_reg;
        is_free_next    = is_free_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_old_next    = res_old_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && out_stall;

        bm_we     = 1'b0;
        bm_re     = 1'b0;
        bm_waddr  = '0;
        bm_raddr  = '0;
        bm_wdata  = bm_rdata;
        ref_we    = 1'b0;
        ref_re    = 1'b0;
        ref_waddr = fcnt_reg;
        ref_raddr = fcnt_reg;
        ref_wdata = ref_rdata;

        in_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                // Every count to one, every bitmap word to all ones.
                ref_we    = 1'b1;
                ref_wdata = REF_ONE;
                if ((XW+1)'(fcnt_reg) < (XW+1)'(NWORDS))
                begin
                    bm_we    = 1'b1;
                    bm_waddr = WIW'(fcnt_reg);
                    bm_wdata = '1;
                end
                if (fcnt_reg == FIW'(FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fcnt_next = fcnt_reg + FIW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_old_next    = '0;
                    is_free_next    = (func_t'(in_item.func) == FN_FREE);
                    unique case (func_t'(in_item.func))
                        FN_ALLOC:
                        begin
                            issue_next = '0;
                            state_next = S_SCAN;
                        end
                        FN_FREE, FN_ADD_REF:
                        begin
                            fcnt_next = frame32[FIW-1:0];
                            if ((func_t'(in_item.func) == FN_FREE)
                                && (frame32 < 32'(protect_reg)))
                            begin
                                res_status_next = ST_PROTECTED;
                                state_next      = S_DONE;
                            end
                            else if (frame32 >= 32'(FRAMES))
                            begin
                                res_status_next = ST_OUT_OF_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ref_re     = 1'b1;
                                ref_raddr  = frame32[FIW-1:0];
                                bm_re      = 1'b1;
                                bm_raddr   = WIW'(frame32[FIW-1:0] >> 5);
                                state_next = S_LOOKUP;
                            end
                        end
                        FN_INIT:
                        begin
                            if (start_x < end_x)
                            begin
                                fcnt_next  = FIW'(start_x);
                                state_next = S_INIT_REF;
                            end
                            else
                            begin
                                used_next  = fstart_reg;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // One word issued and one word checked per cycle.
                if (chk_valid_reg && zf_found)
                begin
                    fcnt_next  = found_frame;
                    bm_we      = 1'b1;
                    bm_waddr   = WIW'(chk_word_reg);
                    bm_wdata   = bm_rdata | (32'd1 << zf_idx);
                    ref_re     = 1'b1;
                    ref_raddr  = found_frame;
                    state_next = S_ALLOC_UPD;
                end
                else if ((XW+1)'(issue_reg) < lim_words)
                begin
                    bm_re          = 1'b1;
                    bm_raddr       = WIW'(issue_reg);
                    chk_valid_next = 1'b1;
                    chk_word_next  = issue_reg;
                    issue_next     = issue_reg + WCW'(1);
                end
                else
                begin
                    res_status_next = ST_NO_FREE;
                    state_next      = S_DONE;
                end
            end

            S_ALLOC_UPD:
            begin
                ref_we       = 1'b1;
                ref_wdata    = (ref_rdata < REF_MAX) ? ref_rdata + REF_ONE : ref_rdata;
                res_old_next = 16'(ref_rdata);
                res_addr_next = addr_wide[31:0];
                if (used_reg != 16'hFFFF)
                begin
                    used_next = used_reg + 16'd1;
                end
                state_next = S_DONE;
            end

            S_LOOKUP:
            begin
                res_old_next = 16'(ref_rdata);
                state_next   = S_DONE;
                if (is_free_reg)
                begin
                    if (ref_rdata == '0)
                    begin
                        res_status_next = ST_DOUBLE_FREE;
                    end
                    else if (ref_rdata > REF_ONE)
                    begin
                        ref_we          = 1'b1;
                        ref_wdata       = ref_rdata - REF_ONE;
                        res_status_next = ST_STILL_REF;
                    end
                    else
                    begin
                        ref_we    = 1'b1;
                        ref_wdata = '0;
                        bm_we     = 1'b1;
                        bm_waddr  = WIW'(fcnt_reg >> 5);
                        bm_wdata  = bm_rdata & ~(32'd1 << fcnt_reg[4:0]);
                        if (used_reg != 16'd0)
                        begin
                            used_next = used_reg - 16'd1;
                        end
                    end
                end
                else if (ref_rdata == REF_MAX)
                begin
                    res_status_next = ST_REF_SAT;
                end
                else
                begin
                    ref_we    = 1'b1;
                    ref_wdata = ref_rdata + REF_ONE;
                end
            end

            S_INIT_REF:
            begin
                ref_we    = 1'b1;
                ref_wdata = '0;
                if ((XW+1)'(fcnt_reg) == last_x)
                begin
                    wcnt_next  = WIW'(start_x >> 5);
                    state_next = S_INIT_BMRD;
                end
                else
                begin
                    fcnt_next = fcnt_reg + FIW'(1);
                end
            end

            S_INIT_BMRD:
            begin
                bm_re      = 1'b1;
                bm_raddr   = wcnt_reg;
                state_next = S_INIT_BMWR;
            end

            S_INIT_BMWR:
            begin
                bm_we    = 1'b1;
                bm_waddr = wcnt_reg;
                bm_wdata = bm_rdata & ~init_mask;
                if ((XW+1)'(wcnt_reg) == (last_x >> 5))
                begin
                    used_next  = fstart_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    wcnt_next  = wcnt_reg + WIW'(1);
                    state_next = S_INIT_BMRD;
                end
            end

            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = res_status_reg;
                    out_item_next.result_addr = res_addr_reg;
                    out_item_next.old_refs    = res_old_reg;
                    out_item_next.used_frames = used_reg;
                    out_item_next.free_frames = (total_reg > used_reg)
                                                ? total_reg - used_reg : 16'd0;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in work");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !(out_valid_reg && out_stall)) |=> out_valid)
        else $error("finished item not presented");

    a_alloc_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_UPD) |-> $past(state_reg == S_SCAN))
        else $error("allocation update without a scan hit");

    a_lookup_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> $past(state_reg == S_IDLE))
        else $error("lookup without an accepted item");

endmodule
